### rtl/core/svps_pkg.sv
package svps_pkg;

    localparam int CHANNELS   = 12;
    localparam int CH_W       = 4;
    localparam int DUTY_W     = 8;
    localparam int SLOT_W     = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int PS_W       = 5;

    localparam logic [DUTY_W-1:0] DUTY0_RESET         = 8'd150;
    localparam logic [7:0]        FRAME_RELOAD_RESET  = 8'd150;
    localparam logic [7:0]        END_RELOAD_RESET    = 8'd250;
    localparam logic [PS_W-1:0]   POSTSCALE_RESET     = 5'd7;
    localparam logic [7:0]        FRAME_DIVIDER_RESET = 8'd16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_RELOAD  = 2'd0,
        CFG_END_RELOAD    = 2'd1,
        CFG_POSTSCALE     = 2'd2,
        CFG_FRAME_DIVIDER = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic              mode;
        logic [CH_W-1:0]   channel;
        logic [DUTY_W-1:0] duty_value;
    } t_item;

    typedef struct packed {
        logic [CHANNELS-1:0] servo_pins;
        logic                burst_active;
        logic [CH_W-1:0]     slot_index;
    } t_result;

endpackage

### rtl/core/svps_if.sv
interface svps_item_if;
    logic                               valid;
    logic                               ready;
    logic                               mode;
    logic [svps_pkg::CH_W-1:0]          channel;
    logic [svps_pkg::DUTY_W-1:0]        duty_value;

    modport source (output valid, output mode, output channel, output duty_value,
                    input ready);
    modport sink   (input valid, input mode, input channel, input duty_value,
                    output ready);
endinterface

interface svps_result_if;
    logic                               valid;
    logic                               ready;
    logic [svps_pkg::CHANNELS-1:0]      servo_pins;
    logic                               burst_active;
    logic [svps_pkg::CH_W-1:0]          slot_index;

    modport source (output valid, output servo_pins, output burst_active,
                    output slot_index, input ready);
    modport sink   (input valid, input servo_pins, input burst_active,
                    input slot_index, output ready);
endinterface

### rtl/core/svps_core.sv
module svps_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [svps_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [svps_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_accept,
    input  svps_pkg::t_item                     i_item,
    output svps_pkg::t_result                   o_result
);

    logic [svps_pkg::DUTY_W-1:0] r_duty [svps_pkg::CHANNELS];
    logic [svps_pkg::DUTY_W-1:0] n_duty [svps_pkg::CHANNELS];
    logic [7:0]                  r_frame_count, n_frame_count;
    logic [7:0]                  r_div_count, n_div_count;
    logic [svps_pkg::SLOT_W-1:0] r_slot_count, n_slot_count;
    logic [svps_pkg::DUTY_W-1:0] r_period, n_period;
    logic [svps_pkg::CH_W-1:0]   r_step, n_step;
    logic                        r_armed, n_armed;
    logic [svps_pkg::CHANNELS-1:0] r_pins, n_pins;

    logic [7:0]                  r_frame_reload;
    logic [7:0]                  r_end_reload;
    logic [svps_pkg::PS_W-1:0]   r_postscale;
    logic [7:0]                  r_frame_divider;

    logic [svps_pkg::PS_W-1:0]   w_ps_eff;
    logic [7:0]                  w_div_eff;
    logic [svps_pkg::SLOT_W:0]   w_limit;
    logic [svps_pkg::SLOT_W:0]   w_slot_next;
    logic [8:0]                  w_div_next;
    logic                        w_frame_tick;
    logic                        w_expire;
    logic [svps_pkg::CHANNELS-1:0] w_bit_cur;
    logic [svps_pkg::CHANNELS-1:0] w_bit_prev;

    assign w_ps_eff  = (r_postscale == '0) ? svps_pkg::PS_W'(1) : r_postscale;
    assign w_div_eff = (r_frame_divider == '0) ? 8'd1 : r_frame_divider;
    assign w_limit   = {5'd0, {1'b0, r_period} + 9'd1}
                       * {{(svps_pkg::SLOT_W+1-svps_pkg::PS_W){1'b0}}, w_ps_eff};
    assign w_slot_next  = {1'b0, r_slot_count} + (svps_pkg::SLOT_W+1)'(1);
    assign w_div_next   = {1'b0, r_div_count} + 9'd1;
    assign w_frame_tick = w_div_next >= {1'b0, w_div_eff};
    assign w_expire     = w_slot_next >= w_limit;
    assign w_bit_cur    = svps_pkg::CHANNELS'(1) << r_step;
    assign w_bit_prev   = svps_pkg::CHANNELS'(1) << (r_step - svps_pkg::CH_W'(1));

    always_comb begin
        n_duty        = r_duty;
        n_frame_count = r_frame_count;
        n_div_count   = r_div_count;
        n_slot_count  = r_slot_count;
        n_period      = r_period;
        n_step        = r_step;
        n_armed       = r_armed;
        n_pins        = r_pins;
        if (i_item.mode) begin
            if (i_item.channel < svps_pkg::CH_W'(svps_pkg::CHANNELS)) begin
                n_duty[i_item.channel] = i_item.duty_value;
            end
        end else begin
            if (w_frame_tick) begin
                n_div_count = '0;
                if (r_frame_count == '0) begin
                    n_armed       = 1'b1;
                    n_frame_count = r_frame_reload - 8'd1;
                end else begin
                    n_frame_count = r_frame_count - 8'd1;
                end
            end else begin
                n_div_count = w_div_next[7:0];
            end
            if (w_expire) begin
                n_slot_count = '0;
                if (n_armed) begin
                    if (r_step < svps_pkg::CH_W'(svps_pkg::CHANNELS)) begin
                        if (r_duty[r_step] != '0) begin
                            n_period = r_duty[r_step];
                            n_pins   = n_pins | w_bit_cur;
                        end
                        if (r_step != '0) begin
                            n_pins = n_pins & ~w_bit_prev;
                        end
                        n_step = r_step + svps_pkg::CH_W'(1);
                    end else begin
                        n_pins        = r_pins & ~(svps_pkg::CHANNELS'(1)
                                        << (svps_pkg::CHANNELS - 1));
                        n_step        = '0;
                        n_armed       = 1'b0;
                        n_frame_count = r_end_reload;
                    end
                end
            end else begin
                n_slot_count = w_slot_next[svps_pkg::SLOT_W-1:0];
            end
        end
    end

    assign o_result.servo_pins   = n_pins;
    assign o_result.burst_active = n_armed;
    assign o_result.slot_index   = n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < svps_pkg::CHANNELS; i++) begin
                r_duty[i] <= '0;
            end
            r_duty[0]     <= svps_pkg::DUTY0_RESET;
            r_frame_count <= 8'd1;
            r_div_count   <= '0;
            r_slot_count  <= '0;
            r_period      <= svps_pkg::DUTY_W'(1);
            r_step        <= '0;
            r_armed       <= 1'b0;
            r_pins        <= '0;
        end else if (i_accept) begin
            r_duty        <= n_duty;
            r_frame_count <= n_frame_count;
            r_div_count   <= n_div_count;
            r_slot_count  <= n_slot_count;
            r_period      <= n_period;
            r_step        <= n_step;
            r_armed       <= n_armed;
            r_pins        <= n_pins;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_reload  <= svps_pkg::FRAME_RELOAD_RESET;
            r_end_reload    <= svps_pkg::END_RELOAD_RESET;
            r_postscale     <= svps_pkg::POSTSCALE_RESET;
            r_frame_divider <= svps_pkg::FRAME_DIVIDER_RESET;
        end else if (i_cfg_we) begin
            case (svps_pkg::t_cfg_idx'(i_cfg_idx))
                svps_pkg::CFG_FRAME_RELOAD:  r_frame_reload  <= i_cfg_data;
                svps_pkg::CFG_END_RELOAD:    r_end_reload    <= i_cfg_data;
                svps_pkg::CFG_POSTSCALE:     r_postscale     <= i_cfg_data[svps_pkg::PS_W-1:0];
                svps_pkg::CFG_FRAME_DIVIDER: r_frame_divider <= i_cfg_data;
                default: ;
            endcase
        end
    end

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= svps_pkg::CH_W'(svps_pkg::CHANNELS))
        else $error("step index beyond end-of-burst step");

    a_pins_idle_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_armed |-> (r_pins == '0))
        else $error("pin high outside a burst");

    a_one_pin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(r_pins))
        else $error("more than one pin high");

    a_burst_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_armed) |-> (r_step == '0))
        else $error("burst ended without step reset");

endmodule

### rtl/core/svps_skid.sv
module svps_skid (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  svps_pkg::t_result   i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output svps_pkg::t_result   o_data
);

    logic               r_main_valid, n_main_valid;
    logic               r_skid_valid, n_skid_valid;
    svps_pkg::t_result  r_main, n_main;
    svps_pkg::t_result  r_skid, n_skid;
    logic               w_pop;
    logic               w_push;

    assign o_ready = !r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;
    assign w_pop   = r_main_valid && i_ready;
    assign w_push  = i_valid && !r_skid_valid;

    always_comb begin
        n_main_valid = r_main_valid;
        n_skid_valid = r_skid_valid;
        n_main       = r_main;
        n_skid       = r_skid;
        if (w_pop) begin
            if (r_skid_valid) begin
                n_main       = r_skid;
                n_skid_valid = 1'b0;
            end else begin
                n_main_valid = w_push;
                n_main       = i_data;
            end
        end else if (w_push) begin
            if (!r_main_valid) begin
                n_main_valid = 1'b1;
                n_main       = i_data;
            end else begin
                n_skid_valid = 1'b1;
                n_skid       = i_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_main_valid <= n_main_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_main <= n_main;
        r_skid <= n_skid;
    end

endmodule

### rtl/core/multichannel_servo_pulse_sequencer.sv
// Twelve-channel servo pulse sequencer. Each input transaction is either one
// time-base tick or a duty write, and each returns one result transaction with
// the pin levels, the burst flag and the next burst step, taken after the
// update. One transaction is accepted every clock cycle while the output buffer
// has room; its result is registered in that buffer. The buffer holds two
// entries, so input keeps flowing into the second entry when the output stalls,
// after which input waits for the sink. Configuration writes take effect on
// the next cycle and belong between transactions only while the block is idle.
module multichannel_servo_pulse_sequencer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [svps_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [svps_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    svps_item_if.sink                           i_in_ch,
    svps_result_if.source                       o_out_ch
);

    logic               w_ready;
    logic               w_accept;
    svps_pkg::t_item    w_item;
    svps_pkg::t_result  w_result;
    svps_pkg::t_result  w_out;

    assign i_in_ch.ready     = w_ready;
    assign w_accept          = i_in_ch.valid && w_ready;
    assign w_item.mode       = i_in_ch.mode;
    assign w_item.channel    = i_in_ch.channel;
    assign w_item.duty_value = i_in_ch.duty_value;

    svps_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_accept   (w_accept),
        .i_item     (w_item),
        .o_result   (w_result)
    );

    svps_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_ch.valid),
        .o_ready (w_ready),
        .i_data  (w_result),
        .o_valid (o_out_ch.valid),
        .i_ready (o_out_ch.ready),
        .o_data  (w_out)
    );

    assign o_out_ch.servo_pins   = w_out.servo_pins;
    assign o_out_ch.burst_active = w_out.burst_active;
    assign o_out_ch.slot_index   = w_out.slot_index;

endmodule
